// ----- hw/rtl/arh_pkg.sv -----
// arh_pkg: shared constants for the arrowhead endpoint pipeline.
// No dependencies; imported by arh_cordic_stage and arrowhead_endpoints.
package arh_pkg;

    localparam int LEN_W          = 6;
    localparam int OUT_W          = 12;
    localparam int PRESCALE_BITS  = 24;
    localparam int FRAC_BITS      = 16;
    localparam int ROUND_SHIFT    = 32;
    localparam int HALF_SHIFT     = 15;

    // barb vector width: head_length in Q16 with CORDIC gain headroom
    localparam int UW = LEN_W + FRAC_BITS + 3;

    localparam logic [FRAC_BITS-1:0] INV_GAIN_Q16   = 16'd39797;
    localparam logic signed [17:0]   HALF_SQRT3_Q16 = 18'sd56756;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
    localparam logic [1:0] REG_HEAD_LENGTH = 2'd2;

    localparam logic [LEN_W-1:0] HEAD_LENGTH_RST = 6'd8;

endpackage

// ----- hw/rtl/arh_cordic_stage.sv -----
// arh_cordic_stage: one registered CORDIC micro-rotation with valid/ready.
// Vectoring on (x, y) steers the matching rotation of the barb vector (u, v).
// Depends on arh_pkg.
module arh_cordic_stage #(
    parameter int XW    = 37,
    parameter int SIDEW = 21,
    parameter int SHIFT = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_skip,
    input  logic signed [XW-1:0]   i_x,
    input  logic signed [XW-1:0]   i_y,
    input  logic signed [arh_pkg::UW-1:0] i_u,
    input  logic signed [arh_pkg::UW-1:0] i_v,
    input  logic [SIDEW-1:0]       i_side,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_skip,
    output logic signed [XW-1:0]   o_x,
    output logic signed [XW-1:0]   o_y,
    output logic signed [arh_pkg::UW-1:0] o_u,
    output logic signed [arh_pkg::UW-1:0] o_v,
    output logic [SIDEW-1:0]       o_side
);
    import arh_pkg::*;

    logic                 r_valid;
    logic                 r_skip;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [UW-1:0] r_u, r_v;
    logic [SIDEW-1:0]     r_side;

    logic signed [XW-1:0] n_x, n_y;
    logic signed [UW-1:0] n_u, n_v;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        if (i_skip) begin
            n_x = i_x;
            n_y = i_y;
            n_u = i_u;
            n_v = i_v;
        end else if (i_y >= 0) begin
            n_x = i_x + (i_y >>> SHIFT);
            n_y = i_y - (i_x >>> SHIFT);
            n_u = i_u - (i_v >>> SHIFT);
            n_v = i_v + (i_u >>> SHIFT);
        end else begin
            n_x = i_x - (i_y >>> SHIFT);
            n_y = i_y + (i_x >>> SHIFT);
            n_u = i_u + (i_v >>> SHIFT);
            n_v = i_v - (i_u >>> SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_skip <= i_skip;
            r_x    <= n_x;
            r_y    <= n_y;
            r_u    <= n_u;
            r_v    <= n_v;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_skip  = r_skip;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_u     = r_u;
    assign o_v     = r_v;
    assign o_side  = r_side;

endmodule

// ----- hw/rtl/arrowhead_endpoints.sv -----
// arrowhead_endpoints: top level, APB register file and barb endpoint pipeline.
// Depends on arh_pkg and arh_cordic_stage.
//
// Usage: a tip point (i_tip_x, i_tip_y) enters on the tip channel
// (i_tip_valid / o_tip_ready). Each transfer yields exactly one result on
// the barb channel (o_barb_valid / i_barb_ready): the two arrowhead barb
// endpoints at +150 and +210 degrees from the origin-to-tip direction,
// head_length pixels from the tip, rounded to whole pixels.
// origin_x, origin_y and head_length sit on the APB port at 0x0, 0x4, 0x8;
// change them only while the pipeline is empty.
// The registers are one entry stage, one register per CORDIC micro-rotation,
// one multiply stage and one output stage. Throughput is one transfer per cycle
// while the receiver does not stall, set by the unrolled CORDIC chain.
// Each stage holds its own valid bit and accepts when empty or draining, so
// bubbles collapse while the receiver stalls; a full stall backs up to
// o_tip_ready without losing or repeating a transfer.
// Reset empties the pipeline and loads origin (50, 550) and head_length 8.
module arrowhead_endpoints #(
    parameter int COORD_BITS    = 10,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [arh_pkg::ADDR_W-1:0]      paddr,
    input  logic [arh_pkg::DATA_W-1:0]      pwdata,
    output logic [arh_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    input  logic                            i_tip_valid,
    output logic                            o_tip_ready,
    input  logic [COORD_BITS-1:0]           i_tip_x,
    input  logic [COORD_BITS-1:0]           i_tip_y,
    output logic                            o_barb_valid,
    input  logic                            i_barb_ready,
    output logic signed [arh_pkg::OUT_W-1:0] o_first_barb_x,
    output logic signed [arh_pkg::OUT_W-1:0] o_first_barb_y,
    output logic signed [arh_pkg::OUT_W-1:0] o_second_barb_x,
    output logic signed [arh_pkg::OUT_W-1:0] o_second_barb_y
);
    import arh_pkg::*;

    localparam int DW    = COORD_BITS + 1;
    localparam int XW    = COORD_BITS + PRESCALE_BITS + 3;
    localparam int SIDEW = 2 * COORD_BITS + 1;
    localparam int PW    = UW + 18;
    localparam int SW    = PW + 2;
    localparam logic signed [SW-1:0] RND = {{(SW-ROUND_SHIFT){1'b0}}, 1'b1,
                                            {(ROUND_SHIFT-1){1'b0}}};

    // configuration registers
    logic [COORD_BITS-1:0] r_origin_x, r_origin_y;
    logic [LEN_W-1:0]      r_head_length;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x    <= COORD_BITS'(50);
            r_origin_y    <= COORD_BITS'(550);
            r_head_length <= HEAD_LENGTH_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_ORIGIN_X:    r_origin_x    <= COORD_BITS'(pwdata);
                REG_ORIGIN_Y:    r_origin_y    <= COORD_BITS'(pwdata);
                REG_HEAD_LENGTH: r_head_length <= LEN_W'(pwdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ORIGIN_X:    prdata = DATA_W'(r_origin_x);
            REG_ORIGIN_Y:    prdata = DATA_W'(r_origin_y);
            REG_HEAD_LENGTH: prdata = DATA_W'(r_head_length);
            default:         prdata = '0;
        endcase
    end

    // pipeline handshake wires: index k feeds CORDIC stage k
    logic                 w_vld  [0:CORDIC_STAGES];
    logic                 w_rdy  [0:CORDIC_STAGES];
    logic                 w_skip [0:CORDIC_STAGES];
    logic signed [XW-1:0] w_x    [0:CORDIC_STAGES];
    logic signed [XW-1:0] w_y    [0:CORDIC_STAGES];
    logic signed [UW-1:0] w_u    [0:CORDIC_STAGES];
    logic signed [UW-1:0] w_v    [0:CORDIC_STAGES];
    logic [SIDEW-1:0]     w_side [0:CORDIC_STAGES];

    // entry stage: differences, half-plane fold, barb vector seed
    logic signed [DW-1:0] n_dx, n_dy, n_adx, n_ady;
    logic                 n_flip, n_skip;
    logic signed [UW-1:0] n_u0;
    logic                 r_e_valid, r_e_skip;
    logic signed [XW-1:0] r_e_x, r_e_y;
    logic signed [UW-1:0] r_e_u;
    logic [SIDEW-1:0]     r_e_side;

    assign o_tip_ready = !r_e_valid || w_rdy[0];

    always_comb begin
        n_dx   = $signed({1'b0, i_tip_x}) - $signed({1'b0, r_origin_x});
        n_dy   = $signed({1'b0, i_tip_y}) - $signed({1'b0, r_origin_y});
        n_flip = n_dx < 0;
        n_skip = (n_dx == 0) && (n_dy == 0);
        n_adx  = n_flip ? -n_dx : n_dx;
        n_ady  = n_flip ? -n_dy : n_dy;
        if (n_skip) begin
            n_u0 = $signed(UW'({r_head_length, {FRAC_BITS{1'b0}}}));
        end else begin
            n_u0 = $signed(UW'(r_head_length) * UW'(INV_GAIN_Q16));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (o_tip_ready) begin
            r_e_valid <= i_tip_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tip_valid && o_tip_ready) begin
            r_e_skip <= n_skip;
            r_e_x    <= XW'(n_adx) <<< PRESCALE_BITS;
            r_e_y    <= XW'(n_ady) <<< PRESCALE_BITS;
            r_e_u    <= n_u0;
            r_e_side <= {n_flip, i_tip_y, i_tip_x};
        end
    end

    assign w_vld[0]  = r_e_valid;
    assign w_skip[0] = r_e_skip;
    assign w_x[0]    = r_e_x;
    assign w_y[0]    = r_e_y;
    assign w_u[0]    = r_e_u;
    assign w_v[0]    = '0;
    assign w_side[0] = r_e_side;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        arh_cordic_stage #(
            .XW    (XW),
            .SIDEW (SIDEW),
            .SHIFT (k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[k]),
            .o_ready (w_rdy[k]),
            .i_skip  (w_skip[k]),
            .i_x     (w_x[k]),
            .i_y     (w_y[k]),
            .i_u     (w_u[k]),
            .i_v     (w_v[k]),
            .i_side  (w_side[k]),
            .o_valid (w_vld[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_skip  (w_skip[k+1]),
            .o_x     (w_x[k+1]),
            .o_y     (w_y[k+1]),
            .o_u     (w_u[k+1]),
            .o_v     (w_v[k+1]),
            .o_side  (w_side[k+1])
        );
    end

    // multiply stage: undo fold, products with sqrt(3)/2 and 1/2 in Q32
    logic [COORD_BITS-1:0] end_tx, end_ty;
    logic                  end_flip;
    logic signed [UW-1:0]  n_uf, n_vf;
    logic                  r_m_valid, m_ready, o_ready_int;
    logic signed [PW-1:0]  r_cu, r_cv, r_hu, r_hv;
    logic [COORD_BITS-1:0] r_m_tx, r_m_ty;

    assign {end_flip, end_ty, end_tx} = w_side[CORDIC_STAGES];
    assign n_uf = end_flip ? -w_u[CORDIC_STAGES] : w_u[CORDIC_STAGES];
    assign n_vf = end_flip ? -w_v[CORDIC_STAGES] : w_v[CORDIC_STAGES];

    assign m_ready              = !r_m_valid || o_ready_int;
    assign w_rdy[CORDIC_STAGES] = m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (m_ready) begin
            r_m_valid <= w_vld[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_vld[CORDIC_STAGES] && m_ready) begin
            r_cu   <= n_uf * HALF_SQRT3_Q16;
            r_cv   <= n_vf * HALF_SQRT3_Q16;
            r_hu   <= PW'(n_uf) <<< HALF_SHIFT;
            r_hv   <= PW'(n_vf) <<< HALF_SHIFT;
            r_m_tx <= end_tx;
            r_m_ty <= end_ty;
        end
    end

    // output stage: round half up, offset from the tip
    logic signed [SW-1:0] n_s0, n_s1, n_s2, n_s3;
    logic                 r_o_valid;
    logic [OUT_W-1:0]     r_fx, r_fy, r_sx, r_sy;

    assign o_ready_int = !r_o_valid || i_barb_ready;

    always_comb begin
        n_s0 = -SW'(r_cu) - SW'(r_hv) + RND;
        n_s1 = -SW'(r_cv) + SW'(r_hu) + RND;
        n_s2 = -SW'(r_cu) + SW'(r_hv) + RND;
        n_s3 = -SW'(r_cv) - SW'(r_hu) + RND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_ready_int) begin
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_m_valid && o_ready_int) begin
            r_fx <= n_s0[ROUND_SHIFT+OUT_W-1:ROUND_SHIFT] + OUT_W'(r_m_tx);
            r_fy <= n_s1[ROUND_SHIFT+OUT_W-1:ROUND_SHIFT] + OUT_W'(r_m_ty);
            r_sx <= n_s2[ROUND_SHIFT+OUT_W-1:ROUND_SHIFT] + OUT_W'(r_m_tx);
            r_sy <= n_s3[ROUND_SHIFT+OUT_W-1:ROUND_SHIFT] + OUT_W'(r_m_ty);
        end
    end

    assign o_barb_valid    = r_o_valid;
    assign o_first_barb_x  = $signed(r_fx);
    assign o_first_barb_y  = $signed(r_fy);
    assign o_second_barb_x = $signed(r_sx);
    assign o_second_barb_y = $signed(r_sy);

endmodule
